// ===== src/cckb_pkg.sv =====
// ----------------------------------------------------------------------------
// cckb_pkg: shared definitions for the clipped colour-key blitter
// Field widths, register indexes, reset values and the structs that pass
// between the register bank, the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package cckb_pkg;

  // Default parameter values
  localparam int MAX_DIMENSION_DEF = 4096;
  localparam int PIXEL_BITS_DEF    = 32;

  // Fixed field widths
  localparam int REG_W     = 13;   // size and origin registers
  localparam int KEY_W     = 32;   // key colour register, also config data
  localparam int ADDR_W    = 24;   // framebuffer write address
  localparam int CFG_IDX_W = 3;    // register index

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_WIDTH    = 3'd0,
    REG_DEST_HEIGHT   = 3'd1,
    REG_SOURCE_WIDTH  = 3'd2,
    REG_SOURCE_HEIGHT = 3'd3,
    REG_ORIGIN_X      = 3'd4,
    REG_ORIGIN_Y      = 3'd5,
    REG_KEY_COLOR     = 3'd6,
    REG_KEY_ENABLE    = 3'd7
  } reg_index_t;

  // Reset values
  localparam logic [REG_W-1:0] DEST_WIDTH_RST    = 13'd320;
  localparam logic [REG_W-1:0] DEST_HEIGHT_RST   = 13'd240;
  localparam logic [REG_W-1:0] SOURCE_WIDTH_RST  = 13'd64;
  localparam logic [REG_W-1:0] SOURCE_HEIGHT_RST = 13'd64;
  localparam logic [REG_W-1:0] ORIGIN_X_RST      = 13'd0;
  localparam logic [REG_W-1:0] ORIGIN_Y_RST      = 13'd0;
  localparam logic [KEY_W-1:0] KEY_COLOR_RST     = 32'd0;
  localparam logic             KEY_ENABLE_RST    = 1'b1;

  // Effective configuration as seen by the front end
  typedef struct packed {
    logic [REG_W-1:0]  dw;       // destination width, clamped
    logic [REG_W-1:0]  dh;       // destination height, clamped
    logic [REG_W-1:0]  sw;       // source width, clamped, never zero
    logic [REG_W-1:0]  sh;       // source height, clamped, never zero
    logic [REG_W-1:0]  ox;       // signed origin column
    logic [REG_W-1:0]  oy;       // signed origin row
    logic [KEY_W-1:0]  key;      // key colour
    logic              key_en;   // key matching on
    logic [ADDR_W-1:0] base0;    // origin_y * dest_width, registered
    logic              hold;     // base0 still settling after a write
  } cfg_t;

  // Queue status
  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_status_t;

endpackage

// ===== src/cckb_ifs.sv =====
// ----------------------------------------------------------------------------
// cckb interfaces: valid/ready channels of the blitter
// Source pixel stream, framebuffer write stream and register write channel.
// ----------------------------------------------------------------------------
interface cckb_pixel_if #(
  parameter int PIXEL_BITS = cckb_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] source_color;

  modport source (output valid, output source_color, input ready);
  modport sink   (input valid, input source_color, output ready);
endinterface

interface cckb_write_if #(
  parameter int PIXEL_BITS = cckb_pkg::PIXEL_BITS_DEF
);
  import cckb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [ADDR_W-1:0]     write_address;
  logic [PIXEL_BITS-1:0] write_color;

  modport source (output valid, output write_address, output write_color, input ready);
  modport sink   (input valid, input write_address, input write_color, output ready);
endinterface

interface cckb_cfg_if;
  import cckb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [KEY_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/cckb_regs.sv =====
// ----------------------------------------------------------------------------
// cckb_regs: configuration register bank
// Holds the eight registers, clamps the sizes and keeps the registered
// product origin_y * dest_width used to start each image.
// ----------------------------------------------------------------------------
module cckb_regs #(
  parameter int MAX_DIMENSION = cckb_pkg::MAX_DIMENSION_DEF
) (
  input  logic              clk,
  input  logic              rst,
  cckb_cfg_if.sink          cfg,
  output cckb_pkg::cfg_t    cfg_q
);
  import cckb_pkg::*;

  logic [REG_W-1:0]        dest_width;
  logic [REG_W-1:0]        dest_height;
  logic [REG_W-1:0]        source_width;
  logic [REG_W-1:0]        source_height;
  logic [REG_W-1:0]        origin_x;
  logic [REG_W-1:0]        origin_y;
  logic [KEY_W-1:0]        key_color;
  logic                    key_enable;
  logic [ADDR_W-1:0]       base0;
  logic                    hold;
  logic signed [2*REG_W:0] base_prod;
  logic [REG_W-1:0]        dw_clamped;
  logic                    wr;

  function automatic logic [REG_W-1:0] dest_dim(input logic [REG_W-1:0] v);
    dest_dim = (32'(v) > MAX_DIMENSION) ? REG_W'(MAX_DIMENSION) : v;
  endfunction

  function automatic logic [REG_W-1:0] src_dim(input logic [REG_W-1:0] v);
    if (v == '0) begin
      src_dim = REG_W'(1);
    end else begin
      src_dim = (32'(v) > MAX_DIMENSION) ? REG_W'(MAX_DIMENSION) : v;
    end
  endfunction

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_width    <= DEST_WIDTH_RST;
      dest_height   <= DEST_HEIGHT_RST;
      source_width  <= SOURCE_WIDTH_RST;
      source_height <= SOURCE_HEIGHT_RST;
      origin_x      <= ORIGIN_X_RST;
      origin_y      <= ORIGIN_Y_RST;
      key_color     <= KEY_COLOR_RST;
      key_enable    <= KEY_ENABLE_RST;
    end else if (wr) begin
      case (reg_index_t'(cfg.index))
        REG_DEST_WIDTH:    dest_width    <= cfg.data[REG_W-1:0];
        REG_DEST_HEIGHT:   dest_height   <= cfg.data[REG_W-1:0];
        REG_SOURCE_WIDTH:  source_width  <= cfg.data[REG_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg.data[REG_W-1:0];
        REG_ORIGIN_X:      origin_x      <= cfg.data[REG_W-1:0];
        REG_ORIGIN_Y:      origin_y      <= cfg.data[REG_W-1:0];
        REG_KEY_COLOR:     key_color     <= cfg.data;
        REG_KEY_ENABLE:    key_enable    <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  // Row base of the first row, one register after the multiplier
  assign dw_clamped = dest_dim(dest_width);
  assign base_prod  = $signed(origin_y) * $signed({1'b0, dw_clamped});

  always_ff @(posedge clk) begin
    if (rst) begin
      base0 <= '0;
      hold  <= 1'b0;
    end else begin
      base0 <= base_prod[ADDR_W-1:0];
      hold  <= wr;
    end
  end

  always_comb begin
    cfg_q.dw     = dw_clamped;
    cfg_q.dh     = dest_dim(dest_height);
    cfg_q.sw     = src_dim(source_width);
    cfg_q.sh     = src_dim(source_height);
    cfg_q.ox     = origin_x;
    cfg_q.oy     = origin_y;
    cfg_q.key    = key_color;
    cfg_q.key_en = key_enable;
    cfg_q.base0  = base0;
    cfg_q.hold   = hold;
  end

endmodule

// ===== src/cckb_front.sv =====
// ----------------------------------------------------------------------------
// cckb_front: pixel acceptance and classification
// Keeps the source column and row counters and the running row base,
// clips each pixel to the destination, applies the colour key and queues
// the survivors.
// ----------------------------------------------------------------------------
module cckb_front #(
  parameter int MAX_DIMENSION = cckb_pkg::MAX_DIMENSION_DEF,
  parameter int PIXEL_BITS    = cckb_pkg::PIXEL_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  cckb_pixel_if.sink                                  pixels,
  input  cckb_pkg::cfg_t                              cfg_q,
  input  cckb_pkg::q_status_t                         q_stat,
  output logic                                        push,
  output logic [2*cckb_pkg::ADDR_W+PIXEL_BITS-1:0]    push_data
);
  import cckb_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIMENSION + 1);
  localparam int DX_W  = ((REG_W > CNT_W + 1) ? REG_W : CNT_W + 1) + 1;

  logic [CNT_W-1:0]       column_count;
  logic [CNT_W-1:0]       row_count;
  logic [ADDR_W-1:0]      row_base_address;
  logic [CNT_W-1:0]       col_inc;
  logic [CNT_W-1:0]       row_inc;
  logic [ADDR_W-1:0]      rb;
  logic signed [DX_W-1:0] dx;
  logic signed [DX_W-1:0] dy;
  logic signed [DX_W-1:0] dw_s;
  logic signed [DX_W-1:0] dh_s;
  logic [ADDR_W-1:0]      dx_addr;
  logic                   on_screen;
  logic                   key_hit;
  logic                   accept;

  assign pixels.ready = !q_stat.full && !cfg_q.hold;
  assign accept       = pixels.valid && pixels.ready;

  // Reload the row base at the start of each image
  assign rb = (column_count == '0 && row_count == '0) ? cfg_q.base0 : row_base_address;

  // Place and clip
  assign dx   = $signed({{(DX_W-REG_W){cfg_q.ox[REG_W-1]}}, cfg_q.ox})
              + $signed({{(DX_W-CNT_W){1'b0}}, column_count});
  assign dy   = $signed({{(DX_W-REG_W){cfg_q.oy[REG_W-1]}}, cfg_q.oy})
              + $signed({{(DX_W-CNT_W){1'b0}}, row_count});
  assign dw_s = $signed({{(DX_W-REG_W){1'b0}}, cfg_q.dw});
  assign dh_s = $signed({{(DX_W-REG_W){1'b0}}, cfg_q.dh});

  assign on_screen = (dx >= 0) && (dx < dw_s) && (dy >= 0) && (dy < dh_s);
  assign key_hit   = cfg_q.key_en && (pixels.source_color == PIXEL_BITS'(cfg_q.key));
  assign dx_addr   = {{(ADDR_W-DX_W){dx[DX_W-1]}}, dx};

  // Queue surviving pixels
  assign push      = accept && on_screen && !key_hit;
  assign push_data = {rb, dx_addr, pixels.source_color};

  assign col_inc = column_count + CNT_W'(1);
  assign row_inc = row_count + CNT_W'(1);

  // Advance the raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count     <= '0;
      row_count        <= '0;
      row_base_address <= '0;
    end else if (accept) begin
      if (32'(col_inc) >= 32'(cfg_q.sw)) begin
        column_count     <= '0;
        row_count        <= (32'(row_inc) >= 32'(cfg_q.sh)) ? '0 : row_inc;
        row_base_address <= rb + ADDR_W'(cfg_q.dw);
      end else begin
        column_count     <= col_inc;
        row_base_address <= rb;
      end
    end
  end

endmodule

// ===== src/cckb_fifo.sv =====
// ----------------------------------------------------------------------------
// cckb_fifo: short queue between front and back
// Two-entry first-in first-out buffer so each side can stall on its own.
// ----------------------------------------------------------------------------
module cckb_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    pop_data,
  output cckb_pkg::q_status_t status
);
  import cckb_pkg::*;

  logic [WIDTH-1:0]   mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (count == '0);
  assign status.count = count;

  assign do_push  = push && !status.full;
  assign do_pop   = pop && !status.empty;
  assign pop_data = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/cckb_back.sv =====
// ----------------------------------------------------------------------------
// cckb_back: framebuffer write issue
// Takes queued pixels, forms the write address and holds each write in
// the output register until the downstream side takes it.
// ----------------------------------------------------------------------------
module cckb_back #(
  parameter int PIXEL_BITS = cckb_pkg::PIXEL_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic [2*cckb_pkg::ADDR_W+PIXEL_BITS-1:0] q_data,
  input  cckb_pkg::q_status_t                      q_stat,
  output logic                                     pop,
  cckb_write_if.source                             writes
);
  import cckb_pkg::*;

  localparam logic [PIXEL_BITS-1:0] COLOR_KEEP = PIXEL_BITS'({KEY_W{1'b1}});

  logic [ADDR_W-1:0]     rb;
  logic [ADDR_W-1:0]     dx_addr;
  logic [PIXEL_BITS-1:0] color;

  assign {rb, dx_addr, color} = q_data;

  // Pop when the output register is free or being emptied
  assign pop = !q_stat.empty && (!writes.valid || writes.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      writes.valid <= 1'b0;
    end else if (pop) begin
      writes.valid <= 1'b1;
    end else if (writes.ready) begin
      writes.valid <= 1'b0;
    end
  end

  // Load address and colour
  always_ff @(posedge clk) begin
    if (pop) begin
      writes.write_address <= rb + dx_addr;
      writes.write_color   <= color & COLOR_KEEP;
    end
  end

endmodule

// ===== src/clipped_color_key_blit.sv =====
// ----------------------------------------------------------------------------
// clipped_color_key_blit: clipped colour-key blitter, top level
// Streams source pixels in raster order, places them at the signed origin,
// clips to the destination and drops key-coloured pixels; each survivor
// becomes one framebuffer write of address and colour.
//
//   channel  dir  handshake      payload
//   pixels   in   valid/ready    source_color
//   writes   out  valid/ready    write_address, write_color
//   cfg      in   valid/ready    index, data (register write)
//
// One pixel per clock sustained while the queue has room and no register
// write holds the input off; a write passes through the queue entry and
// then the output register. Rate is set by the front end's single counter
// update per cycle and the two-entry queue.
// After each register write the pixel input is held off in the next cycle
// while the origin_y * dest_width product register settles.
// Synchronous reset restores register defaults and restarts the raster.
// Either side may stall; the queue and output register absorb it.
// ----------------------------------------------------------------------------
module clipped_color_key_blit #(
  parameter int MAX_DIMENSION = cckb_pkg::MAX_DIMENSION_DEF,
  parameter int PIXEL_BITS    = cckb_pkg::PIXEL_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  cckb_pixel_if.sink   pixels,
  cckb_write_if.source writes,
  cckb_cfg_if.sink     cfg
);
  import cckb_pkg::*;

  localparam int QW = 2 * ADDR_W + PIXEL_BITS;

  cfg_t          cfg_q;
  q_status_t     q_stat;
  logic          push;
  logic [QW-1:0] push_data;
  logic          pop;
  logic [QW-1:0] q_data;

  cckb_regs #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  cckb_front #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .PIXEL_BITS    (PIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels),
    .cfg_q     (cfg_q),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  cckb_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .status    (q_stat)
  );

  cckb_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_data (q_data),
    .q_stat (q_stat),
    .pop    (pop),
    .writes (writes)
  );

  // A register write holds off pixels for the next cycle
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready |=> !pixels.ready)
    else $error("pixel accepted straight after a register write");

  // Queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

  // A new write only comes from a queued pixel
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(writes.valid) |-> $past(!q_stat.empty))
    else $error("write issued with empty queue");

endmodule

// ===== dv/cckb_blit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cckb_blit_checker: framebuffer write predictor and scoreboard
// Watches the register, pixel and write channels of the blitter. Keeps its
// own copy of the registers, raster counters and row base, predicts the
// framebuffer write (if any) for every accepted pixel and compares each
// accepted write, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module cckb_blit_checker (
  input  logic  clk,
  input  logic  rst,
  cckb_pixel_if pixels,
  cckb_write_if writes,
  cckb_cfg_if   cfg,
  output int    mismatch_count,
  output int    writes_pending
);
  import cckb_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [31:0]       color;
  } fb_write_t;

  // Shadow registers
  logic [REG_W-1:0] dest_width;
  logic [REG_W-1:0] dest_height;
  logic [REG_W-1:0] source_width;
  logic [REG_W-1:0] source_height;
  logic [REG_W-1:0] origin_x;
  logic [REG_W-1:0] origin_y;
  logic [KEY_W-1:0] key_color;
  logic             key_enable;

  // Raster position of the next source pixel
  int     column_count;
  int     row_count;
  longint row_base;

  fb_write_t expected_writes[$];
  int        mismatches = 0;

  // Destination sizes saturate at the maximum; zero is kept and clips all
  function automatic int dest_extent(input logic [REG_W-1:0] v);
    return (v > MAX_DIMENSION_DEF) ? MAX_DIMENSION_DEF : int'(v);
  endfunction

  // Source sizes saturate at the maximum and never drop below one
  function automatic int source_extent(input logic [REG_W-1:0] v);
    if (v == 0) return 1;
    return (v > MAX_DIMENSION_DEF) ? MAX_DIMENSION_DEF : int'(v);
  endfunction

  // Place one source pixel, queue its write if it survives, then advance
  function automatic void blit_pixel(input logic [31:0] color);
    int        dw;
    int        dh;
    int        sw;
    int        sh;
    int        ox;
    int        oy;
    longint    dx;
    longint    dy;
    fb_write_t w;
    dw = dest_extent(dest_width);
    dh = dest_extent(dest_height);
    sw = source_extent(source_width);
    sh = source_extent(source_height);
    ox = int'($signed(origin_x));
    oy = int'($signed(origin_y));
    // reload the row base at the start of each image
    if (column_count == 0 && row_count == 0) row_base = longint'(oy) * dw;
    dx = ox + column_count;
    dy = oy + row_count;
    if (dx >= 0 && dx < dw && dy >= 0 && dy < dh &&
        !(key_enable && color == key_color)) begin
      w.addr  = ADDR_W'(row_base + dx);
      w.color = color;
      expected_writes.push_back(w);
    end
    column_count++;
    if (column_count >= sw) begin
      column_count = 0;
      row_count++;
      row_base += dw;
      if (row_count >= sh) row_count = 0;
    end
  endfunction

  always @(posedge clk) begin : track
    fb_write_t w;
    if (rst) begin
      dest_width    = DEST_WIDTH_RST;
      dest_height   = DEST_HEIGHT_RST;
      source_width  = SOURCE_WIDTH_RST;
      source_height = SOURCE_HEIGHT_RST;
      origin_x      = ORIGIN_X_RST;
      origin_y      = ORIGIN_Y_RST;
      key_color     = KEY_COLOR_RST;
      key_enable    = KEY_ENABLE_RST;
      column_count  = 0;
      row_count     = 0;
      row_base      = longint'(int'($signed(ORIGIN_Y_RST))) * dest_extent(DEST_WIDTH_RST);
      expected_writes.delete();
    end else begin
      // compare the outgoing write with the oldest prediction
      if (writes.valid && writes.ready) begin
        if (expected_writes.size() == 0) begin
          $error("unexpected write: write_address %06h write_color %08h",
                 writes.write_address, writes.write_color);
          mismatches++;
        end else begin
          w = expected_writes.pop_front();
          if (writes.write_address !== w.addr) begin
            $error("write_address: expected %06h, actual %06h", w.addr, writes.write_address);
            mismatches++;
          end
          if (writes.write_color !== w.color) begin
            $error("write_color: expected %08h, actual %08h", w.color, writes.write_color);
            mismatches++;
          end
        end
      end
      // mirror register writes
      if (cfg.valid && cfg.ready) begin
        case (reg_index_t'(cfg.index))
          REG_DEST_WIDTH:    dest_width    = cfg.data[REG_W-1:0];
          REG_DEST_HEIGHT:   dest_height   = cfg.data[REG_W-1:0];
          REG_SOURCE_WIDTH:  source_width  = cfg.data[REG_W-1:0];
          REG_SOURCE_HEIGHT: source_height = cfg.data[REG_W-1:0];
          REG_ORIGIN_X:      origin_x      = cfg.data[REG_W-1:0];
          REG_ORIGIN_Y:      origin_y      = cfg.data[REG_W-1:0];
          REG_KEY_COLOR:     key_color     = cfg.data;
          REG_KEY_ENABLE:    key_enable    = cfg.data[0];
          default: ;
        endcase
      end
      if (pixels.valid && pixels.ready) blit_pixel(pixels.source_color);
    end
    mismatch_count <= mismatches;
    writes_pending <= expected_writes.size();
  end

endmodule

// ===== dv/tb_clipped_color_key_blit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clipped_color_key_blit: stimulus and verdict for the blitter
// Programs a sequence of blit settings over the register channel, streams
// source pixels with random gaps and stalls the write side at random. A
// short directed part covers clipping, keying, size clamping and address
// wrap; the rest uses random settings. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb_clipped_color_key_blit;
  import cckb_pkg::*;

  localparam int PIXEL_BUDGET  = 1800;
  localparam int QUIET_TAIL    = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 200;
  localparam int CYCLE_LIMIT   = 300000;

  typedef struct packed {
    logic [REG_W-1:0] dw;
    logic [REG_W-1:0] dh;
    logic [REG_W-1:0] sw;
    logic [REG_W-1:0] sh;
    logic [REG_W-1:0] ox;
    logic [REG_W-1:0] oy;
    logic [31:0]      key;
    logic             en;
  } blit_setting_t;

  logic clk = 1'b0;
  logic rst;
  bit   idle_on = 1'b0;
  int   hold_requests = 0;
  int   cycle_count = 0;
  int   mismatch_count;
  int   writes_pending;

  cckb_pixel_if pixels_if ();
  cckb_write_if writes_if ();
  cckb_cfg_if   cfg_if ();

  clipped_color_key_blit u_dut (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixels_if),
    .writes (writes_if),
    .cfg    (cfg_if)
  );

  cckb_blit_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .pixels         (pixels_if),
    .writes         (writes_if),
    .cfg            (cfg_if),
    .mismatch_count (mismatch_count),
    .writes_pending (writes_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Write side: random stall bursts, plus a long hold-off on request
  initial begin : write_sink
    int holds_done;
    int hold;
    holds_done = 0;
    writes_if.ready <= 1'b0;
    @(negedge clk);
    forever begin
      if (hold_requests > holds_done) begin
        holds_done++;
        writes_if.ready <= 1'b0;
        for (hold = 0; hold < LONG_HOLD; hold++) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        writes_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        writes_if.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic blit_setting_t make_setting(input int dw, input int dh, input int sw,
                                                 input int sh, input int ox, input int oy,
                                                 input logic [31:0] key, input logic en);
    blit_setting_t s;
    s.dw  = REG_W'(dw);
    s.dh  = REG_W'(dh);
    s.sw  = REG_W'(sw);
    s.sh  = REG_W'(sh);
    s.ox  = REG_W'(ox);
    s.oy  = REG_W'(oy);
    s.key = key;
    s.en  = en;
    return s;
  endfunction

  // Size register values at and beyond the limits of the legal range
  function automatic logic [REG_W-1:0] extreme_extent();
    case ($urandom_range(0, 3))
      0:       return REG_W'(0);
      1:       return REG_W'(1);
      2:       return REG_W'(MAX_DIMENSION_DEF);
      default: return {REG_W{1'b1}};
    endcase
  endfunction

  // Mostly small blits that wrap often, with the odd extreme field
  function automatic blit_setting_t random_setting();
    blit_setting_t s;
    s = make_setting($urandom_range(1, 40), $urandom_range(1, 30), $urandom_range(1, 12),
                     $urandom_range(1, 8), int'($urandom_range(0, 50)) - 15,
                     int'($urandom_range(0, 40)) - 10, $urandom(), $urandom_range(0, 3) != 0);
    if ($urandom_range(0, 7) == 0) s.dw = extreme_extent();
    if ($urandom_range(0, 7) == 0) s.dh = extreme_extent();
    if ($urandom_range(0, 7) == 0) s.sw = extreme_extent();
    if ($urandom_range(0, 7) == 0) s.sh = extreme_extent();
    if ($urandom_range(0, 9) == 0) s.ox = $urandom_range(0, 1) ? 13'h0FFF : 13'h1000;
    if ($urandom_range(0, 9) == 0) s.oy = $urandom_range(0, 1) ? 13'h0FFF : 13'h1000;
    return s;
  endfunction

  function automatic logic [31:0] pick_color(input logic [31:0] key);
    case ($urandom_range(0, 15))
      0, 1, 2, 3: return key;
      4:          return 32'h0000_0000;
      5:          return 32'hFFFF_FFFF;
      default:    return $urandom();
    endcase
  endfunction

  // Fill the unused upper data bits with noise; the block must ignore them
  function automatic logic [31:0] with_noise(input logic [31:0] v, input int w);
    logic [31:0] noise;
    noise = $urandom();
    return (noise & ~((32'h1 << w) - 32'h1)) | v;
  endfunction

  // Present one register write; valid stays high for a following one
  task automatic write_reg(input reg_index_t idx, input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_setting(input blit_setting_t s);
    write_reg(REG_DEST_WIDTH,    with_noise(32'(s.dw), REG_W));
    write_reg(REG_DEST_HEIGHT,   with_noise(32'(s.dh), REG_W));
    write_reg(REG_SOURCE_WIDTH,  with_noise(32'(s.sw), REG_W));
    write_reg(REG_SOURCE_HEIGHT, with_noise(32'(s.sh), REG_W));
    write_reg(REG_ORIGIN_X,      with_noise(32'(s.ox), REG_W));
    write_reg(REG_ORIGIN_Y,      with_noise(32'(s.oy), REG_W));
    write_reg(REG_KEY_COLOR,     s.key);
    write_reg(REG_KEY_ENABLE,    with_noise(32'(s.en), 1));
    cfg_if.valid <= 1'b0;
  endtask

  // Offer one pixel, after an optional gap; valid stays high on return
  task automatic push_pixel(input logic [31:0] color);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      pixels_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    pixels_if.valid        <= 1'b1;
    pixels_if.source_color <= color;
    @(posedge clk);
    while (!pixels_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending, wait for every predicted write, then let the pipe settle
  task automatic drain();
    pixels_if.valid <= 1'b0;
    while (writes_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    blit_setting_t s;
    int sent;
    int count;
    int i;
    rst                    <= 1'b1;
    pixels_if.valid        <= 1'b0;
    pixels_if.source_color <= 32'h0;
    cfg_if.valid           <= 1'b0;
    cfg_if.index           <= REG_DEST_WIDTH;
    cfg_if.data            <= 32'h0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: key colour zero is dropped
    push_pixel(32'h0000_0000);
    push_pixel(32'hFFFF_FFFF);
    push_pixel(32'h0000_0001);
    push_pixel(32'h8000_0000);
    push_pixel(32'h0000_0000);
    drain();

    // Zero destination clips all; zero source sizes act as one
    apply_setting(make_setting(0, 0, 0, 0, 0, 0, 32'h0, 1'b1));
    push_pixel(32'h5555_5555);
    push_pixel(32'hAAAA_AAAA);
    drain();

    // Bottom row of the largest frame, then a keyed pixel ends the row
    apply_setting(make_setting(4096, 4096, 2, 4, 0, 4095, 32'hFFFF_FFFF, 1'b1));
    push_pixel(32'h0000_0001);
    push_pixel(32'hFFFF_FFFF);
    drain();

    // Origin moved mid-image: the running row base wraps the address
    apply_setting(make_setting(4096, 4096, 2, 4, 0, 0, 32'hFFFF_FFFF, 1'b0));
    push_pixel(32'hFFFF_FFFF);
    push_pixel(32'h7FFF_FFFF);
    drain();

    // Oversized registers and a blit wholly off-screen
    apply_setting(make_setting(8191, 8191, 8191, 8191, -4096, -4096, 32'h1234_5678, 1'b1));
    push_pixel(32'h1234_5678);
    push_pixel(32'h9ABC_DEF0);
    drain();

    // Small frame clipped on the left and at the bottom
    apply_setting(make_setting(5, 3, 3, 2, -1, 2, 32'h0, 1'b1));
    push_pixel(32'h0000_0000);
    push_pixel(32'h0000_0001);
    push_pixel(32'h0000_0000);
    push_pixel(32'h00FF_00FF);
    push_pixel(32'hFF00_FF00);
    push_pixel(32'h0000_0000);
    push_pixel(32'h1357_9BDF);
    drain();

    // Hold the write side off while pixels keep coming, so the block backs up
    apply_setting(make_setting(64, 64, 8, 8, 0, 0, 32'h0, 1'b0));
    hold_requests++;
    for (i = 0; i < 40; i++) push_pixel($urandom());
    drain();

    // Random settings, each followed by a full drain
    sent = 0;
    while (sent < PIXEL_BUDGET) begin
      s       = random_setting();
      count   = $urandom_range(10, 120);
      idle_on = (sent < PIXEL_BUDGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      apply_setting(s);
      for (i = 0; i < count; i++) push_pixel(pick_color(s.key));
      drain();
      sent += count;
    end

    if (mismatch_count == 0 && writes_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cckb_pkg.sv
src/cckb_ifs.sv
src/cckb_regs.sv
src/cckb_front.sv
src/cckb_fifo.sv
src/cckb_back.sv
src/clipped_color_key_blit.sv
dv/cckb_blit_checker.sv
dv/tb_clipped_color_key_blit.sv
